// File: src/bole_pkg.sv
// Shared types, codes and sizes for the bounded ordered list engine.
package bole_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int REQ_W    = 4;
	localparam int POS_W    = 5;
	localparam int ST_W     = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD_HEAD = 4'd0,
		REQ_ADD_TAIL = 4'd1,
		REQ_ADD_AT   = 4'd2,
		REQ_DEL_HEAD = 4'd3,
		REQ_DEL_TAIL = 4'd4,
		REQ_DEL_AT   = 4'd5,
		REQ_UPDATE   = 4'd6,
		REQ_SEARCH   = 4'd7,
		REQ_CLEAR    = 4'd8
	} req_e_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_e_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE,
		OP_WRITE
	} cell_op_t;

	// Command broadcast to every cell of the row
	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] idx;
	} cell_cmd_t;

	// Result of one request, before it is registered
	typedef struct packed {
		status_e_t        status;
		logic [IDX_W-1:0] index;
		logic [CNT_W-1:0] count;
		logic             take_old;
	} req_res_t;

endpackage

// File: src/bole_cell.sv
// One list cell: holds one entry, shifts from either neighbor, compares with the key.
module bole_cell
	import bole_pkg::*;
(
	input  logic             clk,
	input  logic [IDX_W-1:0] slot,
	input  cell_cmd_t        cmd,
	input  logic [VAL_W-1:0] left_val,
	input  logic [VAL_W-1:0] right_val,
	input  logic [VAL_W-1:0] wr_val,
	output logic [VAL_W-1:0] entry,
	output logic             match
);

	logic [VAL_W-1:0] value_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INSERT: begin
				if (slot > cmd.idx) begin
					value_q <= left_val;
				end else if (slot == cmd.idx) begin
					value_q <= wr_val;
				end
			end
			OP_DELETE: begin
				if (slot >= cmd.idx) begin
					value_q <= right_val;
				end
			end
			OP_WRITE: begin
				if (slot == cmd.idx) begin
					value_q <= wr_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry = value_q;
	// wr_val doubles as the search key
	assign match = (value_q == wr_val);

endmodule

// File: src/bole_decode.sv
// Request decoder: picks the cell command, status, index and new count.
module bole_decode
	import bole_pkg::*;
(
	input  logic                fire,
	input  logic [REQ_W-1:0]    req,
	input  logic [POS_W-1:0]    pos,
	input  logic [CNT_W-1:0]    cnt,
	input  logic [CAPACITY-1:0] match,
	output cell_cmd_t           cmd,
	output req_res_t            res
);

	logic             full;
	logic [IDX_W-1:0] ix;

	assign full = (cnt >= CNT_W'(CAPACITY));

	always_comb begin
		cmd.op       = OP_HOLD;
		cmd.idx      = '0;
		ix           = '0;
		res.status   = ST_OK;
		res.index    = '0;
		res.count    = cnt;
		res.take_old = 1'b0;
		unique case (req) inside
			REQ_ADD_HEAD, REQ_ADD_TAIL, REQ_ADD_AT: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					if (req == REQ_ADD_HEAD || (req == REQ_ADD_AT && pos == '0)) begin
						ix = '0;
					end else if (req == REQ_ADD_TAIL || POS_W'(pos) >= POS_W'(cnt)) begin
						ix = cnt[IDX_W-1:0];
					end else begin
						ix = pos[IDX_W-1:0];
					end
					cmd.op    = OP_INSERT;
					cmd.idx   = ix;
					res.index = ix;
					res.count = cnt + CNT_W'(1);
				end
			end
			REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_AT: begin
				if (cnt == '0) begin
					res.status = ST_EMPTY;
				end else begin
					if (req == REQ_DEL_HEAD) begin
						ix = '0;
					end else if (req == REQ_DEL_TAIL
							|| POS_W'(pos) >= POS_W'(cnt - CNT_W'(1))) begin
						ix = IDX_W'(cnt - CNT_W'(1));
					end else begin
						ix = pos[IDX_W-1:0];
					end
					cmd.op    = OP_DELETE;
					cmd.idx   = ix;
					res.index = ix;
					res.count = cnt - CNT_W'(1);
				end
			end
			REQ_UPDATE: begin
				if (POS_W'(pos) >= POS_W'(cnt)) begin
					res.status = ST_RANGE;
				end else begin
					cmd.op       = OP_WRITE;
					cmd.idx      = pos[IDX_W-1:0];
					res.index    = pos[IDX_W-1:0];
					res.take_old = 1'b1;
				end
			end
			REQ_SEARCH: begin
				res.status = ST_NOTFOUND;
				// lowest matching cell in use wins
				for (int i = CAPACITY - 1; i >= 0; i--) begin
					if (match[i] && CNT_W'(i) < cnt) begin
						res.status = ST_OK;
						res.index  = IDX_W'(i);
					end
				end
			end
			REQ_CLEAR: begin
				res.count = '0;
			end
			default: begin
			end
		endcase
		if (!fire) begin
			cmd.op = OP_HOLD;
		end
	end

endmodule

// File: src/bounded_ordered_list_engine.sv
// Top level of the bounded ordered list engine: request stage, cell row, result register.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  request | in_valid / in_ready  | req_type, position, value
//  result  | out_valid / out_ready| status, result_index, entry_count, old_value
//
// Each request is first registered in the request stage; then all cells
// shift, write or compare at once and the result register is loaded.
// A new request is taken while a result still waits; the row acts only once
// the result register is free. Reset clears the count; cell contents stay
// undefined until written.
module bounded_ordered_list_engine
	import bole_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [REQ_W-1:0]        req_type,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ST_W-1:0]         status,
	output logic [IDX_W-1:0]        result_index,
	output logic [CNT_W-1:0]        entry_count,
	output logic signed [VAL_W-1:0] old_value
);

	logic                busy_q;
	logic [REQ_W-1:0]    req_s1;
	logic [POS_W-1:0]    pos_s1;
	logic [VAL_W-1:0]    val_s1;
	logic [CNT_W-1:0]    count_q;
	logic                out_valid_q;
	logic [ST_W-1:0]     status_q;
	logic [IDX_W-1:0]    index_q;
	logic [CNT_W-1:0]    ecount_q;
	logic [VAL_W-1:0]    old_q;

	logic                fire;
	cell_cmd_t           cmd;
	req_res_t            res;
	logic [VAL_W-1:0]    cell_val [CAPACITY];
	logic [CAPACITY-1:0] match;

	assign in_ready = !busy_q;
	assign fire     = busy_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				count_q     <= res.count;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= req_type;
			pos_s1 <= position;
			val_s1 <= value;
		end
		if (fire) begin
			status_q <= res.status;
			index_q  <= res.index;
			ecount_q <= res.count;
			old_q    <= res.take_old ? cell_val[pos_s1[IDX_W-1:0]] : '0;
		end
	end

	bole_decode u_decode (
		.fire  (fire),
		.req   (req_s1),
		.pos   (pos_s1),
		.cnt   (count_q),
		.match (match),
		.cmd   (cmd),
		.res   (res)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] left_v;
		logic [VAL_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = cell_val[i];
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = cell_val[i];
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end
		bole_cell u_cell (
			.clk       (clk),
			.slot      (IDX_W'(i)),
			.cmd       (cmd),
			.left_val  (left_v),
			.right_val (right_v),
			.wr_val    (val_s1),
			.entry     (cell_val[i]),
			.match     (match[i])
		);
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_index = index_q;
	assign entry_count  = ecount_q;
	assign old_value    = old_q;

endmodule
